>>> design/plvm_pkg.sv
package plvm_pkg;

  localparam int unsigned SegW     = 5;   // breakpoint index, up to 32 points
  localparam int unsigned DivSteps = 16;  // quotient bits of the interpolation

  localparam logic CfgVoxelType  = 1'b0;
  localparam logic CfgPointCount = 1'b1;

  localparam logic [2:0] VoxU8  = 3'd0;
  localparam logic [2:0] VoxS8  = 3'd1;
  localparam logic [2:0] VoxU16 = 3'd2;
  localparam logic [2:0] VoxS16 = 3'd3;
  localparam logic [2:0] VoxS32 = 3'd4;

  localparam logic OpLoad = 1'b0;
  localparam logic OpMap  = 1'b1;

  localparam logic [1:0] RngInside = 2'd0;
  localparam logic [1:0] RngBelow  = 2'd1;
  localparam logic [1:0] RngAbove  = 2'd2;

  localparam logic [15:0] NarrowMax = 16'd255;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_MUL,
    S_DIV,
    S_FIN
  } plvm_state_e;

  // Record that walks the breakpoint cells
  typedef struct packed {
    logic                vld;
    logic signed [32:0]  v;
    logic signed [31:0]  first_raw;
    logic [15:0]         first_disp;
    logic signed [31:0]  last_raw;
    logic [15:0]         last_disp;
    logic [SegW-1:0]     seg;
    logic signed [31:0]  lo;
    logic signed [31:0]  hi;
    logic [15:0]         d_lo;
    logic [15:0]         d_hi;
  } plvm_srch_t;

  // Record that walks the divider cells
  typedef struct packed {
    logic                 vld;
    logic [48:0]          rem;
    logic [32:0]          w;
    logic [DivSteps-1:0]  quo;
  } plvm_div_t;

endpackage

>>> design/plvm_if.sv
interface plvm_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [2:0]         point_index;
  logic signed [31:0] point_raw;
  logic [15:0]        point_display;
  logic [31:0]        sample_bits;

  modport source (output valid, operation, point_index, point_raw, point_display,
                  sample_bits, input ready);
  modport sink (input valid, operation, point_index, point_raw, point_display,
                sample_bits, output ready);
endinterface

interface plvm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] display_value;
  logic [7:0]  pixel;
  logic [2:0]  segment;
  logic [1:0]  range_flag;

  modport source (output valid, display_value, pixel, segment, range_flag, input ready);
  modport sink (input valid, display_value, pixel, segment, range_flag, output ready);
endinterface

>>> design/plvm_seg_cell.sv
module plvm_seg_cell import plvm_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic signed [31:0] wr_raw_i,
  input  logic [15:0]        wr_disp_i,
  input  logic [SegW-1:0]    last_idx_i,
  input  logic signed [31:0] nxt_raw_i,
  input  logic [15:0]        nxt_disp_i,
  input  plvm_srch_t         rec_i,
  output logic signed [31:0] raw_o,
  output logic [15:0]        disp_o,
  output plvm_srch_t         rec_o
);

  localparam logic [SegW-1:0] IdxC = SegW'(IDX);

  logic signed [31:0] raw_q;
  logic [15:0]        disp_q;
  plvm_srch_t         rec_d, rec_q;
  logic               hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      raw_q  <= wr_raw_i;
      disp_q <= wr_disp_i;
    end
  end

  assign hit = (IdxC < last_idx_i) &&
               (rec_i.v >= $signed({raw_q[31], raw_q})) &&
               (rec_i.v <= $signed({nxt_raw_i[31], nxt_raw_i}));

  always_comb begin
    rec_d = rec_i;
    if (IDX == 0) begin
      rec_d.first_raw  = raw_q;
      rec_d.first_disp = disp_q;
      rec_d.seg        = '0;
      rec_d.lo         = raw_q;
      rec_d.hi         = raw_q;
      rec_d.d_lo       = disp_q;
      rec_d.d_hi       = disp_q;
    end
    if (IdxC == last_idx_i) begin
      rec_d.last_raw  = raw_q;
      rec_d.last_disp = disp_q;
    end
    // a later segment overrides an earlier one
    if (hit) begin
      rec_d.seg  = IdxC;
      rec_d.lo   = raw_q;
      rec_d.hi   = nxt_raw_i;
      rec_d.d_lo = disp_q;
      rec_d.d_hi = nxt_disp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign raw_o  = raw_q;
  assign disp_o = disp_q;
  assign rec_o  = rec_q;

endmodule

>>> design/plvm_div_cell.sv
module plvm_div_cell import plvm_pkg::*; #(
  parameter int unsigned SHIFT = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  plvm_div_t rec_i,
  output plvm_div_t rec_o
);

  plvm_div_t   rec_d, rec_q;
  logic [48:0] trial;

  assign trial = 49'(rec_i.w) << SHIFT;

  always_comb begin
    rec_d = rec_i;
    if (rec_i.rem >= trial) begin
      rec_d.rem        = rec_i.rem - trial;
      rec_d.quo[SHIFT] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule

>>> design/piecewise_linear_voxel_mapper.sv
// Piecewise-linear voxel mapper. A load request writes one breakpoint slot. A
// map request decodes the sample by voxel type, walks it through a row of
// MAX_POINTS breakpoint cells (one cell per cycle) to find the last segment
// holding it, forms offset times display step in a multiply state, and divides
// by the segment width in a row of 16 restoring divider cells. Requests are
// taken one at a time, and a new request may be accepted while a finished
// result still waits in the output register.
module piecewise_linear_voxel_mapper import plvm_pkg::*; #(
  parameter int unsigned MAX_POINTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_data_i,
  plvm_in_if.sink     req_i,
  plvm_out_if.source  rsp_o
);

  localparam logic [SegW:0] MaxPts = (SegW + 1)'(MAX_POINTS);

  plvm_state_e state_q, state_d;

  logic [2:0] voxel_type_q;
  logic [3:0] point_count_q;

  logic [SegW:0]   used_pts;
  logic [SegW-1:0] last_idx;

  logic       req_acc;
  logic       cap_srch, cap_div, load_out;

  plvm_srch_t         srch_in_q;
  plvm_srch_t         rec_w [MAX_POINTS+1];
  logic signed [31:0] raw_w [MAX_POINTS];
  logic [15:0]        disp_w [MAX_POINTS];

  plvm_div_t div_in_q;
  plvm_div_t div_w [DivSteps+1];

  logic signed [32:0] v_dec;

  logic [32:0] off_q, w_q;
  logic [15:0] mag_q, base_q;
  logic        neg_q, qz_q, wide_q;
  logic [2:0]  seg_q;
  logic [1:0]  flag_q;
  logic [15:0] quo_q;
  logic        rem_nz_q;

  logic        out_vld_q;
  logic [15:0] out_disp_q;
  logic [7:0]  out_pix_q;
  logic [2:0]  out_seg_q;
  logic [1:0]  out_flag_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voxel_type_q  <= VoxU8;
      point_count_q <= 4'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgVoxelType:  voxel_type_q  <= cfg_data_i[2:0];
        CfgPointCount: point_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    used_pts = (SegW + 1)'(point_count_q);
    if (used_pts < (SegW + 1)'(2)) used_pts = (SegW + 1)'(2);
    if (used_pts > MaxPts) used_pts = MaxPts;
  end
  assign last_idx = SegW'(used_pts - (SegW + 1)'(1));

  always_comb begin
    case (voxel_type_q)
      VoxS8:   v_dec = 33'($signed(req_i.sample_bits[7:0]));
      VoxU16:  v_dec = {17'd0, req_i.sample_bits[15:0]};
      VoxS16:  v_dec = 33'($signed(req_i.sample_bits[15:0]));
      VoxS32:  v_dec = 33'($signed(req_i.sample_bits));
      default: v_dec = {25'd0, req_i.sample_bits[7:0]};
    endcase
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cap_srch = 1'b0;
    cap_div  = 1'b0;
    load_out = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_acc && req_i.operation == OpMap) state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (rec_w[MAX_POINTS].vld) begin
          cap_srch = 1'b1;
          state_d  = S_MUL;
        end
      end
      S_MUL: state_d = S_DIV;
      S_DIV: begin
        if (div_w[DivSteps].vld) begin
          cap_div = 1'b1;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_vld_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // launch into the breakpoint row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srch_in_q <= '0;
    end else begin
      srch_in_q.vld <= req_acc && (req_i.operation == OpMap);
      if (req_acc) begin
        srch_in_q.v <= v_dec;
      end
    end
  end

  assign rec_w[0] = srch_in_q;

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_pt
    logic               wr_en;
    logic signed [31:0] nxt_raw;
    logic [15:0]        nxt_disp;

    assign wr_en = req_acc && (req_i.operation == OpLoad) &&
                   ({{(SegW - 3){1'b0}}, req_i.point_index} == SegW'(i));

    if (i < MAX_POINTS - 1) begin : g_mid
      assign nxt_raw  = raw_w[i+1];
      assign nxt_disp = disp_w[i+1];
    end else begin : g_end
      assign nxt_raw  = raw_w[i];
      assign nxt_disp = disp_w[i];
    end

    plvm_seg_cell #(.IDX(i)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (wr_en),
      .wr_raw_i   (req_i.point_raw),
      .wr_disp_i  (req_i.point_display),
      .last_idx_i (last_idx),
      .nxt_raw_i  (nxt_raw),
      .nxt_disp_i (nxt_disp),
      .rec_i      (rec_w[i]),
      .raw_o      (raw_w[i]),
      .disp_o     (disp_w[i]),
      .rec_o      (rec_w[i+1])
    );
  end

  // segment decision
  plvm_srch_t  res;
  logic        below, above;
  logic [16:0] dd;
  assign res   = rec_w[MAX_POINTS];
  assign below = res.v < $signed({res.first_raw[31], res.first_raw});
  assign above = res.v > $signed({res.last_raw[31], res.last_raw});
  assign dd    = {1'b0, res.d_hi} - {1'b0, res.d_lo};

  always_ff @(posedge clk_i) begin
    if (cap_srch) begin
      off_q  <= res.v - $signed({res.lo[31], res.lo});
      w_q    <= $signed({res.hi[31], res.hi}) - $signed({res.lo[31], res.lo});
      neg_q  <= dd[16];
      mag_q  <= dd[16] ? 16'(-dd) : dd[15:0];
      wide_q <= res.last_disp > NarrowMax;
      qz_q   <= below || above || (res.hi == res.lo);
      if (below) begin
        flag_q <= RngBelow;
        seg_q  <= '0;
        base_q <= res.first_disp;
      end else if (above) begin
        flag_q <= RngAbove;
        seg_q  <= 3'(last_idx - SegW'(1));
        base_q <= res.last_disp;
      end else begin
        flag_q <= RngInside;
        seg_q  <= 3'(res.seg);
        base_q <= res.d_lo;
      end
    end
  end

  // multiply and launch into the divider row
  logic [48:0] prod;
  assign prod = off_q * mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_in_q <= '0;
    end else begin
      div_in_q.vld <= (state_q == S_MUL);
      div_in_q.rem <= prod;
      div_in_q.w   <= w_q;
      div_in_q.quo <= '0;
    end
  end

  assign div_w[0] = div_in_q;

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    plvm_div_cell #(.SHIFT(DivSteps - 1 - j)) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .rec_i  (div_w[j]),
      .rec_o  (div_w[j+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (cap_div) begin
      quo_q    <= div_w[DivSteps].quo;
      rem_nz_q <= div_w[DivSteps].rem != '0;
    end
  end

  // round a negative step away from zero, then add to the lower point
  logic [15:0] q_adj, pv;
  assign q_adj = (neg_q && rem_nz_q) ? quo_q + 16'd1 : quo_q;
  assign pv    = qz_q ? base_q : (neg_q ? base_q - q_adj : base_q + q_adj);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_disp_q <= pv;
      out_pix_q  <= wide_q ? pv[15:8] : pv[7:0];
      out_seg_q  <= seg_q;
      out_flag_q <= flag_q;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.display_value = out_disp_q;
  assign rsp_o.pixel         = out_pix_q;
  assign rsp_o.segment       = out_seg_q;
  assign rsp_o.range_flag    = out_flag_q;

  a_srch_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_w[MAX_POINTS].vld |-> state_q == S_SEARCH)
    else $error("search result outside search state");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_w[DivSteps].vld |-> state_q == S_DIV)
    else $error("divider result outside divide state");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == S_FIN)
    else $error("result raised outside finish state");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !srch_in_q.vld || state_q == S_SEARCH)
    else $error("search launched while busy");

endmodule

>>> dv/tb_piecewise_linear_voxel_mapper.sv
`timescale 1ns / 100ps

module tb_piecewise_linear_voxel_mapper;
  import plvm_pkg::*;

  localparam int unsigned NumPoints  = 8;
  localparam int unsigned SettleCyc  = 40;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [15:0] display_value;
    logic [7:0]  pixel;
    logic [2:0]  segment;
    logic [1:0]  range_flag;
  } mapped_pixel_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_idx_i;
  logic [3:0] cfg_data_i;

  plvm_in_if  req_if ();
  plvm_out_if rsp_if ();

  piecewise_linear_voxel_mapper #(.MAX_POINTS(NumPoints)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // Mirror of the block's settings and breakpoint memory
  logic [2:0]  vox_type_q;
  logic [3:0]  point_count_q;
  int          raw_pts[NumPoints];
  logic [15:0] disp_pts[NumPoints];

  mapped_pixel_t pending_maps[$];
  int unsigned   error_count;
  int unsigned   cycle_count;
  bit            no_idle;

  initial begin
    clk_i = 1'b0;
  end
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout", $time);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic longint decode_voxel(input logic [31:0] bits);
    case (vox_type_q)
      VoxS8:   return $signed(bits[7:0]);
      VoxU16:  return bits[15:0];
      VoxS16:  return $signed(bits[15:0]);
      VoxS32:  return $signed(bits);
      default: return bits[7:0];
    endcase
  endfunction

  function automatic mapped_pixel_t predict_mapping(input logic [31:0] bits);
    mapped_pixel_t res;
    longint v, lo, hi, w, dd, q, off;
    int unsigned n, last;
    logic [15:0] pv;
    n = (point_count_q < 2) ? 2 : (point_count_q > NumPoints) ? NumPoints : point_count_q;
    last = n - 1;
    v = decode_voxel(bits);
    res = '0;
    if (v < longint'(raw_pts[0])) begin
      res.segment = '0;
      res.range_flag = RngBelow;
      pv = disp_pts[0];
    end else if (v > longint'(raw_pts[last])) begin
      res.segment = 3'(last - 1);
      res.range_flag = RngAbove;
      pv = disp_pts[last];
    end else begin
      res.segment = '0;
      res.range_flag = RngInside;
      pv = disp_pts[0];
      for (int m = 0; m < last; m++) begin
        lo = raw_pts[m];
        hi = raw_pts[m+1];
        if (v >= lo && v <= hi) begin
          w = hi - lo;
          dd = longint'(disp_pts[m+1]) - longint'(disp_pts[m]);
          q = 0;
          res.segment = 3'(m);
          if (w > 0) begin
            off = v - lo;
            // round the magnitude up on a falling segment, away from zero
            if (dd >= 0) q = (off * dd) / w;
            else q = -((off * (-dd) + w - 1) / w);
          end
          pv = 16'(longint'(disp_pts[m]) + q);
        end
      end
    end
    res.display_value = pv;
    res.pixel = (disp_pts[last] > NarrowMax) ? pv[15:8] : pv[7:0];
    return res;
  endfunction

  task automatic send_request(input logic op, input logic [2:0] idx, input int raw,
                              input logic [15:0] disp, input logic [31:0] bits);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.operation     <= op;
    req_if.point_index   <= idx;
    req_if.point_raw     <= raw;
    req_if.point_display <= disp;
    req_if.sample_bits   <= bits;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (op == OpLoad) begin
      raw_pts[idx]  = raw;
      disp_pts[idx] = disp;
    end else begin
      pending_maps.push_back(predict_mapping(bits));
    end
  endtask

  task automatic map_sample(input logic [31:0] bits);
    send_request(OpMap, 3'd0, $urandom, 16'($urandom), bits);
  endtask

  task automatic load_point(input logic [2:0] idx, input int raw, input logic [15:0] disp);
    send_request(OpLoad, idx, raw, disp, $urandom);
  endtask

  // Hold until every result is in, then let the pipeline empty
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_maps.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CfgVoxelType) vox_type_q = data[2:0];
    else point_count_q = data;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    mapped_pixel_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_maps.size() == 0) begin
        $display("%0t unrequested result: actual %0h", $time, rsp_if.display_value);
        error_count++;
      end else begin
        want = pending_maps.pop_front();
        check_field("display_value", want.display_value, rsp_if.display_value);
        check_field("pixel", 16'(want.pixel), 16'(rsp_if.pixel));
        check_field("segment", 16'(want.segment), 16'(rsp_if.segment));
        check_field("range_flag", 16'(want.range_flag), 16'(rsp_if.range_flag));
      end
    end
  end

  // Result side back-pressure
  initial begin
    int unsigned stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!(rsp_if.valid && rsp_if.ready)) @(posedge clk_i);
    end
  end

  function automatic longint type_min(input logic [2:0] t);
    case (t)
      VoxS8:   return -128;
      VoxS16:  return -32768;
      VoxS32:  return -64'sd2147483648;
      default: return 0;
    endcase
  endfunction

  function automatic longint type_max(input logic [2:0] t);
    case (t)
      VoxS8:   return 127;
      VoxU16:  return 65535;
      VoxS16:  return 32767;
      VoxS32:  return 2147483647;
      default: return 255;
    endcase
  endfunction

  function automatic longint rand_in(input longint lo, input longint hi);
    longint span;
    span = hi - lo + 1;
    return lo + longint'({$urandom, $urandom} % span);
  endfunction

  // Put a decoded value back into random sample bits
  function automatic logic [31:0] encode_sample(input longint v);
    logic [31:0] bits;
    bits = $urandom;
    case (vox_type_q)
      VoxU16, VoxS16: bits[15:0] = v[15:0];
      VoxS32:         bits = v[31:0];
      default:        bits[7:0] = v[7:0];
    endcase
    return bits;
  endfunction

  task automatic load_ascending(input bit narrow);
    int pts[$];
    longint lo, hi;
    lo = type_min(vox_type_q);
    hi = type_max(vox_type_q);
    for (int i = 0; i < NumPoints; i++) pts.push_back(int'(rand_in(lo, hi)));
    pts.sort();
    for (int i = 1; i < NumPoints; i++)
      if ($urandom_range(0, 5) == 0) pts[i] = pts[i-1];
    for (int i = 0; i < NumPoints; i++)
      load_point(3'(i), pts[i], narrow ? 16'($urandom_range(0, 255)) : 16'($urandom));
  endtask

  task automatic test_reset_config();
    // voxel type u8 and two points after reset
    load_point(3'd0, 10, 16'd0);
    load_point(3'd1, 200, 16'd255);
    for (int i = 2; i < NumPoints; i++) load_point(3'(i), 300, 16'd255);
    map_sample(32'hFFFF_FF00);
    map_sample(32'h0000_0069);
    map_sample(32'hA5A5_A5FF);
    drain();
  endtask

  task automatic test_field_extremes();
    write_reg(CfgVoxelType, 4'(VoxS32));
    write_reg(CfgPointCount, 4'd8);
    load_point(3'd0, 32'sh8000_0000, 16'd65535);
    load_point(3'd1, -5, 16'd0);
    load_point(3'd2, 0, 16'd40000);
    load_point(3'd3, 0, 16'd100);
    load_point(3'd4, 1000, 16'd65535);
    load_point(3'd5, 7, 16'd3);
    load_point(3'd6, 2147483646, 16'd1);
    load_point(3'd7, 2147483647, 16'd65535);
    map_sample(32'h8000_0000);
    map_sample(32'h7FFF_FFFF);
    map_sample(32'h0000_0000);
    map_sample(32'h4000_0000);
    map_sample(32'hFFFF_FFF0);
    drain();
  endtask

  task automatic test_special_configs();
    write_reg(CfgPointCount, 4'd0);
    map_sample(32'hC000_0000);
    drain();
    write_reg(CfgPointCount, 4'd15);
    write_reg(CfgVoxelType, 4'd7);
    map_sample(32'hFFFF_FF80);
    drain();
    write_reg(CfgVoxelType, 4'd5);
    map_sample(32'h1234_5603);
    drain();
  endtask

  task automatic test_random(input int unsigned item_goal);
    int unsigned items;
    int unsigned phase_len;
    longint v, lo, hi;
    int unsigned seg;
    items = 0;
    while (items < item_goal) begin
      drain();
      no_idle = ($urandom_range(0, 4) == 0);
      write_reg(CfgVoxelType, ($urandom_range(0, 9) == 0) ? 4'($urandom_range(5, 7))
                                                          : 4'($urandom_range(0, 4)));
      write_reg(CfgPointCount, ($urandom_range(0, 7) == 0) ? 4'($urandom)
                                                           : 4'($urandom_range(2, 8)));
      if ($urandom_range(0, 7) == 0) begin
        // scrambled breakpoints
        for (int i = 0; i < NumPoints; i++) load_point(3'(i), $urandom, 16'($urandom));
      end else begin
        load_ascending($urandom_range(0, 2) == 0);
      end
      items += NumPoints;
      phase_len = $urandom_range(20, 60);
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          load_point(3'($urandom), $urandom, 16'($urandom));
        end else if ($urandom_range(0, 4) == 0) begin
          map_sample($urandom);
        end else begin
          seg = $urandom_range(0, NumPoints - 2);
          lo = raw_pts[seg];
          hi = raw_pts[seg+1];
          if (lo > hi) v = lo;
          else v = rand_in(lo, hi);
          if (v < type_min(vox_type_q) || v > type_max(vox_type_q)) v = lo;
          map_sample(encode_sample(v));
        end
      end
      items += phase_len;
    end
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgVoxelType;
    cfg_data_i    = '0;
    req_if.valid  = 1'b0;
    req_if.operation     = OpLoad;
    req_if.point_index   = '0;
    req_if.point_raw     = '0;
    req_if.point_display = '0;
    req_if.sample_bits   = '0;
    vox_type_q    = VoxU8;
    point_count_q = 4'd2;
    for (int i = 0; i < NumPoints; i++) begin
      raw_pts[i]  = 0;
      disp_pts[i] = '0;
    end
    no_idle     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_config();
    test_field_extremes();
    test_special_configs();
    test_random(1200);

    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> sim.f
design/plvm_pkg.sv
design/plvm_if.sv
design/plvm_seg_cell.sv
design/plvm_div_cell.sv
design/piecewise_linear_voxel_mapper.sv
dv/tb_piecewise_linear_voxel_mapper.sv
